// ===== design/ascii85_stream_encoder_macros.svh =====
// Assertion helpers for the encoder top module.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef ASCII85_STREAM_ENCODER_MACROS_SVH
`define ASCII85_STREAM_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASC85_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ascii85 encoder check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASC85_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ascii85 encoder check failed");

`endif

// ===== design/asc85_pkg.sv =====
package asc85_pkg;

    localparam int NUM_DIGITS = 5;
    localparam int DIGIT_W    = 7;
    localparam int CNT_W      = 3;

    localparam logic [7:0] CHAR_BASE  = 8'h21;
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    localparam logic [7:0] LINE_WIDTH_RESET = 8'd72;

    // floor(v / 85) == (v * RECIP_85) >> RECIP_SHIFT for every 32-bit v.
    localparam logic [31:0] RECIP_85    = 32'd3233857729;
    localparam int          RECIP_SHIFT = 38;

    localparam int FIFO_DEPTH_DEFAULT = 2;

    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic             fin;
        logic             zero;
        logic [CNT_W-1:0] ndigits;
        logic [31:0]      value;
    } job_t;

    typedef struct packed {
        logic                                 fin;
        logic                                 zero;
        logic [CNT_W-1:0]                     ndigits;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== design/ascii85_stream_encoder.sv =====
// Channel   Handshake               Payload                 Transfer
// input     in_valid / in_ready     req_type, data_byte     valid and ready high at clk rise
// output    out_valid / out_ready   out_char, last_of_run   valid and ready high at clk rise
// config    cfg_wr_en               cfg_wr_data             write enable high at clk rise
//
// A byte that does not complete a group is only added to the group and gives nothing.
// A complete group or a finish spends a load state, five multiply steps of the
// base-85 converter and a hand-off state; no new job is taken until the hand-off.
// Characters leave at most one per cycle from the output register.
// Reset clears the control state (not the data registers) and sets the line width to 72.
// A stalled output holds the character sequencer; FIFO_DEPTH jobs queue in the FIFO and one in the converter.
`include "ascii85_stream_encoder_macros.svh"

module ascii85_stream_encoder #(
    parameter int FIFO_DEPTH = asc85_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run
);
    import asc85_pkg::*;

    logic [7:0] line_width_reg;
    logic       push;
    job_t       push_job;
    logic       job_valid;
    logic       job_ready;
    job_t       job;
    fifo_stat_t fifo_stat;
    logic       bnd_valid;
    logic       bnd_ready;
    bundle_t    bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_width_reg <= cfg_wr_data;
        end
    end

    asc85_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .data_byte (data_byte),
        .fifo_full (fifo_stat.full),
        .push      (push),
        .job       (push_job)
    );

    asc85_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (job_ready),
        .pop_valid (job_valid),
        .pop_data  (job),
        .stat      (fifo_stat)
    );

    asc85_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .bnd_valid (bnd_valid),
        .bnd_ready (bnd_ready),
        .bnd       (bnd)
    );

    asc85_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_width  (line_width_reg),
        .bnd_valid   (bnd_valid),
        .bnd_ready   (bnd_ready),
        .bnd         (bnd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

    `ASC85_ASSERT_SAME(a_fifo_status, 1'b1, !(fifo_stat.full && fifo_stat.empty))
    `ASC85_ASSERT_SAME(a_tilde_not_last, out_valid && out_char == CHAR_TILDE, !last_of_run)
    `ASC85_ASSERT_NEXT(a_bundle_held, bnd_valid && !bnd_ready, bnd_valid && $stable(bnd))

endmodule

// ===== design/asc85_front.sv =====
module asc85_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [7:0]          data_byte,
    input  logic                fifo_full,
    output logic                push,
    output asc85_pkg::job_t     job
);
    import asc85_pkg::*;

    logic [31:0] group_reg, group_next;
    logic [1:0]  count_reg, count_next;
    logic [31:0] group_merged;
    logic        accept;

    assign in_ready     = !fifo_full;
    assign accept       = in_valid && in_ready;
    assign group_merged = group_reg | (32'(data_byte) << {~count_reg, 3'b000});
    assign push         = accept && (req_type == REQ_FINISH || count_reg == 2'd3);

    always_comb
    begin
        job.fin     = 1'b0;
        job.zero    = (group_merged == 32'd0);
        job.ndigits = CNT_W'(NUM_DIGITS);
        job.value   = group_merged;
        group_next  = group_reg;
        count_next  = count_reg;
        if (req_type == REQ_FINISH)
        begin
            job.fin     = 1'b1;
            job.zero    = 1'b0;
            job.ndigits = (count_reg == 2'd0) ? CNT_W'(0) : CNT_W'(count_reg) + CNT_W'(1);
            job.value   = group_reg;
        end
        if (accept)
        begin
            if (req_type == REQ_FINISH || count_reg == 2'd3)
            begin
                group_next = 32'd0;
                count_next = 2'd0;
            end
            else
            begin
                group_next = group_merged;
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= 32'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            group_reg <= group_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/asc85_fifo.sv =====
module asc85_fifo #(
    parameter int DEPTH = asc85_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  asc85_pkg::job_t         push_data,
    input  logic                    pop,
    output logic                    pop_valid,
    output asc85_pkg::job_t         pop_data,
    output asc85_pkg::fifo_stat_t   stat
);
    import asc85_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push, do_pop;

    assign stat.full  = (level_reg == LVL_W'(DEPTH));
    assign stat.empty = (level_reg == LVL_W'(0));
    assign pop_valid  = !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== design/asc85_conv.sv =====
module asc85_conv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  asc85_pkg::job_t     job,
    output logic                bnd_valid,
    input  logic                bnd_ready,
    output asc85_pkg::bundle_t  bnd
);
    import asc85_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_DONE = 3'b100
    } conv_state_t;

    conv_state_t      state_reg, state_next;
    logic [31:0]      value_reg, value_next;
    logic [CNT_W-1:0] step_reg, step_next;
    bundle_t          bnd_reg, bnd_next;
    logic [63:0]      product;
    logic [25:0]      quot;
    logic [6:0]       quot_lo;
    logic [6:0]       quot_x85;
    logic [6:0]       rem;

    // Each step peels off the least significant base-85 digit.
    assign product  = 64'(value_reg) * 64'(RECIP_85);
    assign quot     = product[63:RECIP_SHIFT];
    assign quot_lo  = quot[6:0];
    assign quot_x85 = (quot_lo << 6) + (quot_lo << 4) + (quot_lo << 2) + quot_lo;
    assign rem      = value_reg[6:0] - quot_x85;

    assign job_ready = (state_reg == C_IDLE);
    assign bnd_valid = (state_reg == C_DONE);
    assign bnd       = bnd_reg;

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        step_next  = step_reg;
        bnd_next   = bnd_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (job_valid)
                begin
                    value_next       = job.value;
                    step_next        = '0;
                    bnd_next.fin     = job.fin;
                    bnd_next.zero    = job.zero;
                    bnd_next.ndigits = job.ndigits;
                    state_next       = C_RUN;
                end
            end
            C_RUN:
            begin
                value_next      = 32'(quot);
                bnd_next.digits = {bnd_reg.digits[NUM_DIGITS-2:0], rem};
                step_next       = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(NUM_DIGITS - 1))
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                if (bnd_ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        bnd_reg   <= bnd_next;
    end

endmodule

// ===== design/asc85_emit.sv =====
module asc85_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          line_width,
    input  logic                bnd_valid,
    output logic                bnd_ready,
    input  asc85_pkg::bundle_t  bnd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_char,
    output logic                last_of_run
);
    import asc85_pkg::*;

    typedef enum logic [5:0] {
        E_IDLE  = 6'b000001,
        E_CHAR  = 6'b000010,
        E_NL    = 6'b000100,
        E_FIN   = 6'b001000,
        E_TILDE = 6'b010000,
        E_GT    = 6'b100000
    } emit_state_t;

    emit_state_t                        state_reg, state_next;
    logic [7:0]                         pos_reg, pos_next;
    logic [CNT_W-1:0]                   left_reg, left_next;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_reg, digits_next;
    logic                               fin_reg, fin_next;
    logic                               zero_reg, zero_next;
    logic                               ovalid_reg, ovalid_next;
    logic [7:0]                         ochar_reg, ochar_next;
    logic                               olast_reg, olast_next;
    logic                               adv;
    logic                               wrap;
    logic [7:0]                         counted_char;
    logic [CNT_W-1:0]                   load_left;

    assign adv          = !ovalid_reg || out_ready;
    assign wrap         = (pos_reg >= line_width);
    assign counted_char = zero_reg ? CHAR_Z : 8'(digits_reg[0]) + CHAR_BASE;
    assign load_left    = bnd.fin ? bnd.ndigits : (bnd.zero ? CNT_W'(1) : CNT_W'(NUM_DIGITS));
    assign bnd_ready    = (state_reg == E_IDLE);

    assign out_valid   = ovalid_reg;
    assign out_char    = ochar_reg;
    assign last_of_run = olast_reg;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        digits_next = digits_reg;
        fin_next    = fin_reg;
        zero_next   = zero_reg;
        ovalid_next = adv ? 1'b0 : ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (bnd_valid)
                begin
                    digits_next = bnd.digits;
                    fin_next    = bnd.fin;
                    zero_next   = bnd.zero;
                    left_next   = load_left;
                    state_next  = (load_left == CNT_W'(0)) ? E_FIN : E_CHAR;
                end
            end
            E_CHAR:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = counted_char;
                    digits_next = digits_reg >> DIGIT_W;
                    left_next   = left_reg - CNT_W'(1);
                    if (wrap)
                    begin
                        pos_next   = 8'd0;
                        olast_next = 1'b0;
                        state_next = E_NL;
                    end
                    else
                    begin
                        pos_next = pos_reg + 8'd1;
                        if (left_reg == CNT_W'(1))
                        begin
                            olast_next = !fin_reg;
                            state_next = fin_reg ? E_FIN : E_IDLE;
                        end
                        else
                        begin
                            olast_next = 1'b0;
                        end
                    end
                end
            end
            E_NL:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = CHAR_NL;
                    if (left_reg == CNT_W'(0))
                    begin
                        olast_next = !fin_reg;
                        state_next = fin_reg ? E_FIN : E_IDLE;
                    end
                    else
                    begin
                        olast_next = 1'b0;
                        state_next = E_CHAR;
                    end
                end
            end
            E_FIN:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    olast_next  = 1'b0;
                    if ({1'b0, pos_reg} + 9'd2 > {1'b0, line_width})
                    begin
                        ochar_next = CHAR_NL;
                        state_next = E_TILDE;
                    end
                    else
                    begin
                        ochar_next = CHAR_TILDE;
                        state_next = E_GT;
                    end
                end
            end
            E_TILDE:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = CHAR_TILDE;
                    olast_next  = 1'b0;
                    state_next  = E_GT;
                end
            end
            E_GT:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = CHAR_GT;
                    olast_next  = 1'b1;
                    pos_next    = 8'd0;
                    state_next  = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            pos_reg    <= 8'd0;
            left_reg   <= '0;
            fin_reg    <= 1'b0;
            zero_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            left_reg   <= left_next;
            fin_reg    <= fin_next;
            zero_reg   <= zero_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        ochar_reg  <= ochar_next;
        olast_reg  <= olast_next;
    end

endmodule

// ===== bench/ascii85_stream_encoder_tb.sv =====
module ascii85_stream_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asc85_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 3000;
    localparam int IDLE_PCT      = 24;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    typedef struct {
        logic       rt;
        logic [7:0] db;
        bit         typed;
        string      want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       req_type = REQ_DATA;
    logic [7:0] data_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       last_of_run;

    enc_char_t  expected_chars[$];
    enc_char_t  burst[$];
    enc_char_t  head_char;
    stim_row_t  stim_rows[$];

    logic [31:0] grp_word = 32'd0;
    logic [1:0]  grp_bytes = 2'd0;
    logic [7:0]  col = 8'd0;
    logic [7:0]  line_width_q = LINE_WIDTH_RESET;

    bit no_idle = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int flushes = 0;
    int zero_groups = 0;
    int chars_seen = 0;
    int widths_used = 0;
    int stall_cycles = 0;

    ascii85_stream_encoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void put_plain(logic [7:0] c);
        burst.insert(burst.size(), enc_char_t'{ch: c, last: 1'b0});
    endfunction

    // A counted character breaks the line when the old column had reached the width.
    function automatic void put_counted(logic [7:0] c);
        put_plain(c);
        if (col >= line_width_q)
        begin
            col = 8'd0;
            put_plain(CHAR_NL);
        end
        else
        begin
            col = col + 8'd1;
        end
    endfunction

    function automatic void put_digits(logic [31:0] v, int n);
        logic [7:0]  d [5];
        logic [31:0] rest;
        rest = v;
        for (int i = 4; i >= 0; i--)
        begin
            d[i] = 8'(rest % 85);
            rest = rest / 85;
        end
        for (int i = 0; i < n; i++)
            put_counted(CHAR_BASE + d[i]);
    endfunction

    function automatic void encode_item(logic rt, logic [7:0] db);
        burst.delete();
        if (rt == REQ_DATA)
        begin
            grp_word = grp_word | ({24'd0, db} << (8 * (3 - grp_bytes)));
            if (grp_bytes == 2'd3)
            begin
                if (grp_word == 32'd0)
                begin
                    put_counted(CHAR_Z);
                    zero_groups++;
                end
                else
                begin
                    put_digits(grp_word, 5);
                end
                grp_word = 32'd0;
                grp_bytes = 2'd0;
            end
            else
            begin
                grp_bytes = grp_bytes + 2'd1;
            end
        end
        else
        begin
            if (grp_bytes != 2'd0)
                put_digits(grp_word, int'(grp_bytes) + 1);
            if (int'(col) + 2 > int'(line_width_q))
                put_plain(CHAR_NL);
            put_plain(CHAR_TILDE);
            put_plain(CHAR_GT);
            grp_word = 32'd0;
            grp_bytes = 2'd0;
            col = 8'd0;
            flushes++;
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
    endfunction

    task automatic flag_error(string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    task automatic send(logic rt, logic [7:0] db, bit typed = 1'b0, string want = "");
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        req_type <= rt;
        data_byte <= db;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        encode_item(rt, db);
        if (typed)
        begin
            burst.delete();
            for (int i = 0; i < want.len(); i++)
                burst.insert(burst.size(),
                             enc_char_t'{ch: want[i], last: (i == want.len() - 1)});
        end
        foreach (burst[i])
            expected_chars.insert(expected_chars.size(), burst[i]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(logic [7:0] w);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        line_width_q = w;
        widths_used++;
    endtask

    function automatic void add_row(logic rt, logic [7:0] db, bit typed, string want);
        stim_rows.insert(stim_rows.size(),
                         stim_row_t'{rt: rt, db: db, typed: typed, want: want});
    endfunction

    task automatic run_phase(int n, int flush_pct, bit quiet);
        int         mode;
        logic [7:0] b;
        mode = 2;
        no_idle = quiet;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < flush_pct)
            begin
                send(REQ_FINISH, 8'($urandom_range(0, 255)));
            end
            else
            begin
                if (grp_bytes == 2'd0)
                begin
                    mode = $urandom_range(0, 99);
                    mode = (flush_pct == 0) ? 2 : (mode < 15) ? 0 : (mode < 25) ? 1 : 2;
                end
                case (mode)
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = ($urandom_range(0, 99) < 20) ? 8'h00 :
                                 8'($urandom_range(0, 255));
                endcase
                send(REQ_DATA, b);
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        add_row(REQ_FINISH, 8'hA5, 1'b1, "~>");
        add_row(REQ_DATA, 8'h00, 1'b1, "");
        add_row(REQ_DATA, 8'h00, 1'b1, "");
        add_row(REQ_DATA, 8'h00, 1'b1, "");
        add_row(REQ_DATA, 8'h00, 1'b1, "z");
        add_row(REQ_DATA, 8'hFF, 1'b1, "");
        add_row(REQ_DATA, 8'hFF, 1'b1, "");
        add_row(REQ_DATA, 8'hFF, 1'b1, "");
        add_row(REQ_DATA, 8'hFF, 1'b1, "s8W-!");
        add_row(REQ_DATA, 8'h00, 1'b1, "");
        add_row(REQ_FINISH, 8'h00, 1'b1, "!!~>");
        add_row(REQ_DATA, 8'h4D, 1'b1, "");
        add_row(REQ_DATA, 8'h61, 1'b1, "");
        add_row(REQ_DATA, 8'h6E, 1'b1, "");
        add_row(REQ_DATA, 8'h20, 1'b1, "9jqo^");
        add_row(REQ_DATA, 8'hFF, 1'b0, "");
        add_row(REQ_DATA, 8'hFF, 1'b0, "");
        add_row(REQ_DATA, 8'hFF, 1'b0, "");
        add_row(REQ_FINISH, 8'hFF, 1'b0, "");
        add_row(REQ_DATA, 8'h80, 1'b0, "");
        add_row(REQ_DATA, 8'h01, 1'b0, "");
        add_row(REQ_FINISH, 8'h5A, 1'b0, "");

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send(stim_rows[i].rt, stim_rows[i].db, stim_rows[i].typed, stim_rows[i].want);

        // The wide line reaches column 255 and wraps before the width is cut below the column.
        settle();
        set_width(8'd255);
        run_phase(208, 0, 1'b1);
        settle();
        set_width(8'd2);
        run_phase(30, 10, 1'b0);
        settle();
        set_width(8'd0);
        run_phase(30, 10, 1'b0);
        settle();
        set_width(8'd1);
        run_phase(30, 10, 1'b0);
        settle();
        set_width(8'd72);
        run_phase(30, 10, 1'b0);
        settle();
        set_width(8'($urandom_range(0, 255)));
        run_phase(30, 10, 1'b0);
        settle();
        set_width(8'($urandom_range(3, 40)));
        run_phase(30, 10, 1'b0);
        settle();

        if (expected_chars.size() != 0)
            flag_error($sformatf("%0d characters never arrived", expected_chars.size()));
        $display("Sent %0d input transfers, %0d of them flushes, with %0d all-zero groups.",
                 items_sent, flushes, zero_groups);
        $display("Checked %0d output characters across %0d line width settings.",
                 chars_seen, widths_used);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        if (rst_n && out_valid && out_ready)
        begin
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                flag_error($sformatf("unexpected transfer: char 0x%02h last %0b",
                                     out_char, last_of_run));
            end
            else
            begin
                head_char = expected_chars.pop_front();
                if (out_char !== head_char.ch || last_of_run !== head_char.last)
                    flag_error($sformatf("expected char 0x%02h last %0b, got 0x%02h last %0b",
                                         head_char.ch, head_char.last, out_char, last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timed out after %0d cycles without a transfer.", stall_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
